@@ hdl/frt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package frt_pkg;
   localparam int MaxFragments = 16;
   localparam int PoolSlots    = 32;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_CLEAR    = 2'd1;
   localparam logic [1:0] OP_ASSEMBLE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_POOL      = 3'd1;
   localparam logic [2:0] ST_RANGE     = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_OVER      = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  fragment_number;
      logic        is_last;
      logic [7:0]  data_length;
      logic [15:0] buffer_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  slot_index;
      logic [3:0]  fragment_index;
      logic [7:0]  fragment_length;
      logic        all_received;
      logic [11:0] assembled_size;
      logic [5:0]  free_slots;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  status;
      logic [7:0]  fragment_number;
      logic        is_last;
      logic [7:0]  data_length;
      logic [15:0] buffer_limit;
   } cmd_type;
endpackage
`default_nettype wire

@@ hdl/frt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module frt_front #(
   parameter int MAX_FRAGMENTS = frt_pkg::MaxFragments
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire frt_pkg::req_type  req_data,
   input  wire logic [7:0]        max_size,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output frt_pkg::cmd_type       cmd_data
);
   logic             valid_ff, valid_in;
   frt_pkg::cmd_type cmd_ff, cmd_in;
   logic [2:0]       pre_status;

   assign req_ready = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      pre_status = frt_pkg::ST_OK;
      if (req_data.operation == frt_pkg::OP_ADD) begin
         if (32'(req_data.fragment_number) >= MAX_FRAGMENTS) begin
            pre_status = frt_pkg::ST_RANGE;
         end else if (req_data.data_length > max_size) begin
            pre_status = frt_pkg::ST_TOO_LONG;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (req_ready) begin
         valid_in = req_valid;
         cmd_in.operation       = req_data.operation;
         cmd_in.status          = pre_status;
         cmd_in.fragment_number = req_data.fragment_number;
         cmd_in.is_last         = req_data.is_last;
         cmd_in.data_length     = req_data.data_length;
         cmd_in.buffer_limit    = req_data.buffer_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end
endmodule
`default_nettype wire

@@ hdl/frt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module frt_back #(
   parameter int MAX_FRAGMENTS = frt_pkg::MaxFragments,
   parameter int POOL_SLOTS    = frt_pkg::PoolSlots
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire frt_pkg::cmd_type  cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output frt_pkg::rsp_type       rsp_data
);
   localparam int FW = $clog2(MAX_FRAGMENTS);
   localparam int SW = $clog2(POOL_SLOTS);
   localparam int CW = $clog2(POOL_SLOTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_ADD   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [SW-1:0] stack_mem [POOL_SLOTS];
   logic [SW-1:0] slot_mem  [MAX_FRAGMENTS];
   logic [7:0]    len_mem   [MAX_FRAGMENTS];
   logic [CW-1:0] count_ff, count_in;
   logic [MAX_FRAGMENTS-1:0] present_ff, present_in;
   logic          seen_ff, seen_in;
   logic [FW-1:0] lidx_ff, lidx_in;
   logic [FW:0]   idx_ff, idx_in;
   logic [11:0]   sum_ff, sum_in;
   logic          allin_ff, allin_in;
   frt_pkg::cmd_type cmd_ff, cmd_in;
   logic          rvalid_ff, rvalid_in;
   frt_pkg::rsp_type rsp_ff, rsp_in;
   logic [SW:0]   init_ff, init_in;
   logic [SW-1:0] pop_slot;
   logic          stk_we;
   logic [SW-1:0] stk_wa, stk_wd;
   logic          tab_we, tab_slot_we;
   logic [FW-1:0] tab_a, ia;
   logic [SW-1:0] tab_slot;
   logic          more_after;

   assign cmd_ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;
   assign ia        = idx_ff[FW-1:0];
   assign pop_slot  = stack_mem[SW'(count_ff - CW'(1))];

   always_comb begin
      more_after = 1'b0;
      for (int i = 0; i < MAX_FRAGMENTS; i++) begin
         if (i > 32'(idx_ff) && present_ff[i]) more_after = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; present_in = present_ff;
      seen_in = seen_ff; lidx_in = lidx_ff; idx_in = idx_ff; sum_in = sum_ff;
      allin_in = allin_ff; cmd_in = cmd_ff; rvalid_in = rvalid_ff; rsp_in = rsp_ff;
      init_in = init_ff;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
      tab_we = 1'b0; tab_slot_we = 1'b0; tab_a = '0; tab_slot = '0;
      if (rvalid_ff && rsp_ready) rvalid_in = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            stk_we = 1'b1; stk_wa = init_ff[SW-1:0]; stk_wd = init_ff[SW-1:0];
            init_in = init_ff + 1'b1;
            if (32'(init_ff) == POOL_SLOTS - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in = cmd_data;
               idx_in = '0; sum_in = '0; allin_in = 1'b1;
               if (cmd_data.status != frt_pkg::ST_OK) begin
                  state_in = S_SUM;
               end else if (cmd_data.operation == frt_pkg::OP_ADD) begin
                  state_in = S_ADD;
               end else if (cmd_data.operation == frt_pkg::OP_CLEAR) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_SUM;
               end
            end
         end
         S_ADD: begin
            tab_a = cmd_ff.fragment_number[FW-1:0];
            if (present_ff[tab_a]) begin
               tab_we = 1'b1;
            end else if (count_ff == '0) begin
               cmd_in.status = frt_pkg::ST_POOL;
            end else begin
               tab_we = 1'b1; tab_slot_we = 1'b1; tab_slot = pop_slot;
               count_in = count_ff - 1'b1;
               present_in[tab_a] = 1'b1;
            end
            if (tab_we && cmd_ff.is_last) begin
               seen_in = 1'b1; lidx_in = tab_a;
            end
            state_in = S_SUM;
         end
         S_CLEAR: begin
            if (present_ff[ia] && 32'(count_ff) < POOL_SLOTS) begin
               stk_we = 1'b1; stk_wa = count_ff[SW-1:0]; stk_wd = slot_mem[ia];
               count_in = count_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (32'(idx_ff) == MAX_FRAGMENTS - 1) begin
               present_in = '0; seen_in = 1'b0; lidx_in = '0;
               state_in = S_SUM; idx_in = '0;
            end
         end
         S_SUM: begin
            if (idx_ff <= {1'b0, lidx_ff}) begin
               if (present_ff[ia]) sum_in = sum_ff + 12'(len_mem[ia]);
               else allin_in = 1'b0;
            end
            idx_in = idx_ff + 1'b1;
            if (32'(idx_ff) == MAX_FRAGMENTS - 1) begin
               idx_in = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rvalid_ff || rsp_ready) begin
               rsp_in = '0;
               rsp_in.status = cmd_ff.status;
               rsp_in.all_received = allin_ff && seen_ff;
               rsp_in.assembled_size = sum_ff;
               rsp_in.free_slots = 6'(count_ff);
               rsp_in.last_of_run = 1'b1;
               state_in = S_IDLE;
               if (cmd_ff.status == frt_pkg::ST_OK &&
                   cmd_ff.operation == frt_pkg::OP_ADD) begin
                  rsp_in.slot_index = 5'(slot_mem[cmd_ff.fragment_number[FW-1:0]]);
                  rsp_in.fragment_index = 4'(cmd_ff.fragment_number);
                  rsp_in.fragment_length = cmd_ff.data_length;
               end
               if (cmd_ff.operation == frt_pkg::OP_ASSEMBLE &&
                   cmd_ff.status == frt_pkg::ST_OK) begin
                  if (32'(sum_ff) > 32'(cmd_ff.buffer_limit)) begin
                     rsp_in.status = frt_pkg::ST_OVER;
                     rvalid_in = 1'b1;
                  end else if (present_ff != '0) begin
                     state_in = S_EMIT;
                  end else begin
                     rvalid_in = 1'b1;
                  end
               end else begin
                  rvalid_in = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (!present_ff[ia]) begin
               idx_in = idx_ff + 1'b1;
            end else if (!rvalid_ff || rsp_ready) begin
               rsp_in = '0;
               rsp_in.slot_index = 5'(slot_mem[ia]);
               rsp_in.fragment_index = 4'(ia);
               rsp_in.fragment_length = len_mem[ia];
               rsp_in.all_received = allin_ff && seen_ff;
               rsp_in.assembled_size = sum_ff;
               rsp_in.free_slots = 6'(count_ff);
               rsp_in.last_of_run = !more_after;
               rvalid_in = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (!more_after) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_wa] <= stk_wd;
      if (tab_we) len_mem[tab_a] <= cmd_ff.data_length;
      if (tab_slot_we) slot_mem[tab_a] <= tab_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; count_ff <= CW'(POOL_SLOTS); present_ff <= '0;
         seen_ff <= 1'b0; lidx_ff <= '0; idx_ff <= '0; rvalid_ff <= 1'b0;
         init_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; present_ff <= present_in;
         seen_ff <= seen_in; lidx_ff <= lidx_in; idx_ff <= idx_in;
         rvalid_ff <= rvalid_in; init_ff <= init_in;
      end
      sum_ff <= sum_in; allin_ff <= allin_in; cmd_ff <= cmd_in; rsp_ff <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= POOL_SLOTS) else $error("free count above pool size");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && 32'(idx_ff) == MAX_FRAGMENTS - 1) |=> present_ff == '0)
      else $error("clear left fragments");
endmodule
`default_nettype wire

@@ hdl/fragment_reassembly_tracker_unit.sv @@
// channel | direction | handshake
// req_*   | in        | req_valid / req_ready
// rsp_*   | out       | rsp_valid / rsp_ready
// csr_*   | in        | csr_write_enable, no wait
// After the req transfer of an accepted add, rsp_valid rises after load, table update,
// a walk over all entries that recomputes size and completion, and result load. An add
// the front end rejects, an unused code or an assemble skip the update; clear walks
// twice. Assemble then walks the table again, one rsp per held fragment; the back end
// takes the next command in the cycle after the final rsp transfer. After reset the
// free stack is filled with all POOL_SLOTS slots; the front register takes one
// transfer meanwhile, then req_ready stays low. A stalled rsp_ready holds the back end.
`timescale 1ns / 1ps
`default_nettype none
module fragment_reassembly_tracker_unit #(
   parameter int MAX_FRAGMENTS = frt_pkg::MaxFragments,
   parameter int POOL_SLOTS    = frt_pkg::PoolSlots
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire frt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output frt_pkg::rsp_type       rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic [7:0]        csr_write_data
);
   logic [7:0]       max_size_ff;
   logic             cmd_valid, cmd_ready;
   frt_pkg::cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= 8'd255;
      end else if (csr_write_enable) begin
         max_size_ff <= csr_write_data;
      end
   end

   frt_front #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .max_size(max_size_ff), .cmd_valid, .cmd_ready, .cmd_data);

   frt_back #(.MAX_FRAGMENTS(MAX_FRAGMENTS), .POOL_SLOTS(POOL_SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data);
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
   localparam logic [1:0] OP_IDLE = 2'd3;
   localparam int ReportMax = 10;
   localparam int WatchdogLimit = 4000;
   localparam int SettleCycles = 80;
   localparam int LongHold = 400;
   localparam int PhaseItems = 60;

   typedef struct {
      bit               is_cfg;
      logic [7:0]       cfg_value;
      frt_pkg::req_type item;
      bit               has_status;
      logic [2:0]       status;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   frt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   frt_pkg::rsp_type rsp_data;
   logic             csr_write_enable;
   logic [7:0]       csr_write_data;

   logic [4:0]                       pool_stack [frt_pkg::PoolSlots];
   int                               pool_free;
   logic [frt_pkg::MaxFragments-1:0] held;
   logic [4:0]                       held_slot [frt_pkg::MaxFragments];
   logic [7:0]                       held_len [frt_pkg::MaxFragments];
   bit                               tail_seen;
   logic [3:0]                       tail_num;
   logic [7:0]                       slot_max;

   frt_pkg::rsp_type due_rsp [$];
   stim_row_type     stim_rows [$];
   bit               cur_has_status;
   logic [2:0]       cur_status;
   int               errors;
   int               idle_cycles;
   bit               gapless;
   int               rsp_hold;

   fragment_reassembly_tracker_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic frt_pkg::rsp_type packet_view(logic [2:0] st, logic [4:0] sl,
                                                    logic [3:0] ix, logic [7:0] ln,
                                                    bit fin);
      frt_pkg::rsp_type r;
      int               sum;
      bit               whole;
      sum = 0;
      whole = tail_seen;
      for (int i = 0; i <= tail_num; i++) begin
         if (held[i]) begin
            sum += held_len[i];
         end else begin
            whole = 1'b0;
         end
      end
      r.status = st;
      r.slot_index = sl;
      r.fragment_index = ix;
      r.fragment_length = ln;
      r.all_received = whole;
      r.assembled_size = sum[11:0];
      r.free_slots = pool_free[5:0];
      r.last_of_run = fin;
      return r;
   endfunction

   task automatic track_fragment(frt_pkg::req_type q, bit has_st, logic [2:0] st);
      frt_pkg::rsp_type r;
      int               n;
      int               cnt;
      int               k;
      int               first;
      first = due_rsp.size();
      n = q.fragment_number;
      case (q.operation)
         frt_pkg::OP_ADD: begin
            if (n >= frt_pkg::MaxFragments) begin
               r = packet_view(frt_pkg::ST_RANGE, 0, 0, 0, 1'b1);
            end else if (q.data_length > slot_max) begin
               r = packet_view(frt_pkg::ST_TOO_LONG, 0, 0, 0, 1'b1);
            end else if (!held[n] && pool_free == 0) begin
               r = packet_view(frt_pkg::ST_POOL, 0, 0, 0, 1'b1);
            end else begin
               if (!held[n]) begin
                  pool_free--;
                  held_slot[n] = pool_stack[pool_free];
                  held[n] = 1'b1;
               end
               held_len[n] = q.data_length;
               if (q.is_last) begin
                  tail_seen = 1'b1;
                  tail_num = n[3:0];
               end
               r = packet_view(frt_pkg::ST_OK, held_slot[n], n[3:0], q.data_length, 1'b1);
            end
            due_rsp.push_back(r);
         end
         frt_pkg::OP_CLEAR: begin
            for (int i = 0; i < frt_pkg::MaxFragments; i++) begin
               if (held[i] && pool_free < frt_pkg::PoolSlots) begin
                  pool_stack[pool_free] = held_slot[i];
                  pool_free++;
               end
            end
            held = '0;
            tail_seen = 1'b0;
            tail_num = '0;
            due_rsp.push_back(packet_view(frt_pkg::ST_OK, 0, 0, 0, 1'b1));
         end
         frt_pkg::OP_ASSEMBLE: begin
            r = packet_view(frt_pkg::ST_OK, 0, 0, 0, 1'b1);
            cnt = $countones(held);
            if (r.assembled_size > q.buffer_limit) begin
               r.status = frt_pkg::ST_OVER;
               due_rsp.push_back(r);
            end else if (cnt == 0) begin
               due_rsp.push_back(r);
            end else begin
               k = 0;
               for (int i = 0; i < frt_pkg::MaxFragments; i++) begin
                  if (held[i]) begin
                     k++;
                     due_rsp.push_back(packet_view(frt_pkg::ST_OK, held_slot[i], i[3:0],
                                                   held_len[i], k == cnt));
                  end
               end
            end
         end
         default: begin
            due_rsp.push_back(packet_view(frt_pkg::ST_OK, 0, 0, 0, 1'b1));
         end
      endcase
      if (has_st) begin
         due_rsp[first].status = st;
      end
   endtask

   always @(posedge clock) begin
      frt_pkg::rsp_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            track_fragment(req_data, cur_has_status, cur_status);
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (due_rsp.size() == 0) begin
               errors++;
               if (errors <= ReportMax) begin
                  $display("unexpected transfer: %p", rsp_data);
               end
            end else begin
               want = due_rsp.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= ReportMax) begin
                     $display("mismatch at %0t: expected %p, actual %p", $realtime, want,
                              rsp_data);
                  end
               end
            end
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int d;
      rsp_ready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         d = gapless ? 0 : $urandom_range(0, 6);
         if (rsp_hold > 0) begin
            d = rsp_hold;
            rsp_hold = 0;
         end
         if (d > 0) begin
            rsp_ready <= 1'b0;
            repeat (d) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_req(frt_pkg::req_type q, bit has_st, logic [2:0] st);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_has_status = has_st;
      cur_status = st;
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (due_rsp.size() == 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_cfg(logic [7:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      slot_max = v;
   endtask

   task automatic add_row(bit c, logic [7:0] v, logic [1:0] op, logic [7:0] num, bit lst,
                          logic [7:0] len, logic [15:0] lim, bit hs, logic [2:0] st);
      stim_row_type r;
      r.is_cfg = c;
      r.cfg_value = v;
      r.item.operation = op;
      r.item.fragment_number = num;
      r.item.is_last = lst;
      r.item.data_length = len;
      r.item.buffer_limit = lim;
      r.has_status = hs;
      r.status = st;
      stim_rows.push_back(r);
   endtask

   function automatic frt_pkg::req_type random_req();
      frt_pkg::req_type q;
      int               roll;
      roll = $urandom_range(0, 99);
      q.fragment_number = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 255)
                                                       : $urandom_range(0, 15);
      q.is_last = ($urandom_range(0, 4) == 0);
      q.data_length = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, slot_max);
      case ($urandom_range(0, 3))
         0: q.buffer_limit = $urandom_range(0, 4095);
         1: q.buffer_limit = $urandom_range(0, 65535);
         default: q.buffer_limit = 16'hFFFF;
      endcase
      if (roll < 62) begin
         q.operation = frt_pkg::OP_ADD;
      end else if (roll < 70) begin
         q.operation = frt_pkg::OP_CLEAR;
      end else if (roll < 96) begin
         q.operation = frt_pkg::OP_ASSEMBLE;
      end else begin
         q.operation = OP_IDLE;
      end
      return q;
   endfunction

   initial begin
      logic [7:0] v;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      errors = 0;
      idle_cycles = 0;
      gapless = 1'b0;
      rsp_hold = 0;
      cur_has_status = 1'b0;
      cur_status = frt_pkg::ST_OK;
      for (int i = 0; i < frt_pkg::PoolSlots; i++) pool_stack[i] = i[4:0];
      pool_free = frt_pkg::PoolSlots;
      held = '0;
      tail_seen = 1'b0;
      tail_num = '0;
      slot_max = 8'd255;
      for (int i = 0; i < frt_pkg::MaxFragments; i++) begin
         held_slot[i] = '0;
         held_len[i] = '0;
      end

      add_row(0, 0, frt_pkg::OP_ASSEMBLE, 0, 0, 0, 16'h0000, 1, frt_pkg::ST_OK);
      add_row(1, 0, frt_pkg::OP_ADD, 0, 0, 0, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 0, 0, 0, 0, 1, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 1, 0, 1, 0, 1, frt_pkg::ST_TOO_LONG);
      add_row(0, 0, frt_pkg::OP_CLEAR, 0, 0, 0, 0, 1, frt_pkg::ST_OK);
      add_row(1, 255, frt_pkg::OP_ADD, 0, 0, 0, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 16, 1, 5, 0, 1, frt_pkg::ST_RANGE);
      add_row(0, 0, frt_pkg::OP_ADD, 255, 1, 255, 0, 1, frt_pkg::ST_RANGE);
      add_row(0, 0, frt_pkg::OP_ADD, 0, 0, 255, 0, 1, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 1, 0, 10, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 0, 0, 5, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 3, 1, 200, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ASSEMBLE, 0, 0, 0, 16'h0000, 1, frt_pkg::ST_OVER);
      add_row(0, 0, frt_pkg::OP_ASSEMBLE, 0, 0, 0, 16'hFFFF, 0, frt_pkg::ST_OK);
      add_row(0, 0, OP_IDLE, 8'hFF, 1, 8'hFF, 16'hFFFF, 1, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 2, 0, 0, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 15, 1, 255, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 5, 1, 1, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ASSEMBLE, 0, 0, 0, 16'hFFFF, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_CLEAR, 0, 0, 0, 0, 1, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ASSEMBLE, 0, 0, 0, 16'h0000, 1, frt_pkg::ST_OK);
      add_row(1, 1, frt_pkg::OP_ADD, 0, 0, 0, 0, 0, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 4, 1, 1, 0, 1, frt_pkg::ST_OK);
      add_row(0, 0, frt_pkg::OP_ADD, 6, 0, 2, 0, 1, frt_pkg::ST_TOO_LONG);
      add_row(0, 0, frt_pkg::OP_ASSEMBLE, 0, 0, 0, 16'h0001, 0, frt_pkg::ST_OK);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) begin
            settle();
            write_cfg(stim_rows[i].cfg_value);
         end else begin
            send_req(stim_rows[i].item, stim_rows[i].has_status, stim_rows[i].status);
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: v = 8'd255;
            1: v = 8'd1;
            2: v = 8'd128;
            3: v = 8'd255;
            default: v = $urandom_range(1, 255);
         endcase
         write_cfg(v);
         gapless = (ph == 3);
         if (ph == 2) begin
            rsp_hold = LongHold;
         end
         repeat (PhaseItems) send_req(random_req(), 1'b0, frt_pkg::ST_OK);
      end

      settle();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/frt_pkg.sv
hdl/frt_front.sv
hdl/frt_back.sv
hdl/fragment_reassembly_tracker_unit.sv
bench/tb.sv
